>>> rtl/ssht_pkg.sv
// Package for the segment sphere hit test: payload types and datapath widths.
`default_nettype none

package ssht_pkg;

  // Field widths of the request and result.
  localparam int unsigned CoordW = 24;
  localparam int unsigned RsqW   = 48;
  localparam int unsigned TagW   = 8;

  // Datapath widths, all exact.
  localparam int unsigned DiffW    = CoordW + 1;       // d and e components
  localparam int unsigned ProdW    = 2 * DiffW;        // products of two components
  localparam int unsigned LenW     = ProdW;            // |d|^2, unsigned
  localparam int unsigned DotW     = ProdW + 1;        // e.d, signed
  localparam int unsigned CrossW   = ProdW + 1;        // cross product components, signed
  localparam int unsigned MagW     = ProdW;            // magnitude of a cross component
  localparam int unsigned HalfW    = MagW / 2;         // half of a magnitude or of |d|^2
  localparam int unsigned WinW     = DotW + 2;         // window compare width
  localparam int unsigned SqPartW  = 2 * HalfW;        // partial product of a square
  localparam int unsigned RsqHalfW = RsqW / 2;         // half of the squared radius
  localparam int unsigned BndPartW = RsqHalfW + HalfW; // partial product of the bound
  localparam int unsigned SqW      = 2 * MagW;         // squared cross component
  localparam int unsigned BndW     = RsqW + LenW;      // radius_sq * |d|^2

  // Number of register stages from request to result.
  localparam int unsigned NumStages = 8;
  localparam int unsigned CntW      = $clog2(NumStages + 1);

  // One request.
  typedef struct packed {
    logic signed [CoordW-1:0] old_x;
    logic signed [CoordW-1:0] old_y;
    logic signed [CoordW-1:0] old_z;
    logic signed [CoordW-1:0] new_x;
    logic signed [CoordW-1:0] new_y;
    logic signed [CoordW-1:0] new_z;
    logic signed [CoordW-1:0] centre_x;
    logic signed [CoordW-1:0] centre_y;
    logic signed [CoordW-1:0] centre_z;
    logic        [RsqW-1:0]   radius_sq;
    logic        [TagW-1:0]   sphere_tag;
  } ssht_req_t;

  // One result.
  typedef struct packed {
    logic            hit;
    logic            zero_length;
    logic [TagW-1:0] tag_out;
  } ssht_res_t;

endpackage

`default_nettype wire

>>> rtl/segment_sphere_hit_test.sv
// Segment sphere hit test: eight-stage pipeline with exact fixed-point arithmetic.
// Each accepted request moves through the stage registers in order to its result on the output register.
// Throughput: one request per cycle; each stage holds one item and a stage with an
// empty slot or a moving successor takes the next item, so bubbles are squeezed out.
// The pipeline is full and in_ready_o low only when all stages hold items and the
// output is stalled. Reset (asynchronous, active low) empties all stages.
`default_nettype none

module segment_sphere_hit_test
  import ssht_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire ssht_req_t in_req_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output ssht_res_t      out_res_o
);

  // Stage occupancy and flow control.
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages:0]   rdy;
  logic [NumStages-1:0] ld;

  // A stage takes a new item when it is empty or its content moves on.
  always_comb begin
    rdy[NumStages] = out_ready_i;
    for (int i = NumStages - 1; i >= 0; i--) begin
      rdy[i] = ~valid_q[i] | rdy[i+1];
    end
    for (int i = 0; i < NumStages; i++) begin
      if (i == 0) begin
        valid_d[i] = rdy[i] ? in_valid_i : valid_q[i];
        ld[i]      = rdy[i] & in_valid_i;
      end else begin
        valid_d[i] = rdy[i] ? valid_q[i-1] : valid_q[i];
        ld[i]      = rdy[i] & valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NumStages-1];

  // Stage 1: segment vector d = new - old and offset e = old - centre.
  logic signed [DiffW-1:0] s1_d_d [3];
  logic signed [DiffW-1:0] s1_e_d [3];
  logic signed [DiffW-1:0] s1_d_q [3];
  logic signed [DiffW-1:0] s1_e_q [3];
  logic [RsqW-1:0]         s1_rsq_q;
  logic [TagW-1:0]         s1_tag_q;

  always_comb begin
    s1_d_d[0] = $signed({in_req_i.new_x[CoordW-1], in_req_i.new_x})
              - $signed({in_req_i.old_x[CoordW-1], in_req_i.old_x});
    s1_d_d[1] = $signed({in_req_i.new_y[CoordW-1], in_req_i.new_y})
              - $signed({in_req_i.old_y[CoordW-1], in_req_i.old_y});
    s1_d_d[2] = $signed({in_req_i.new_z[CoordW-1], in_req_i.new_z})
              - $signed({in_req_i.old_z[CoordW-1], in_req_i.old_z});
    s1_e_d[0] = $signed({in_req_i.old_x[CoordW-1], in_req_i.old_x})
              - $signed({in_req_i.centre_x[CoordW-1], in_req_i.centre_x});
    s1_e_d[1] = $signed({in_req_i.old_y[CoordW-1], in_req_i.old_y})
              - $signed({in_req_i.centre_y[CoordW-1], in_req_i.centre_y});
    s1_e_d[2] = $signed({in_req_i.old_z[CoordW-1], in_req_i.old_z})
              - $signed({in_req_i.centre_z[CoordW-1], in_req_i.centre_z});
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      s1_d_q   <= s1_d_d;
      s1_e_q   <= s1_e_d;
      s1_rsq_q <= in_req_i.radius_sq;
      s1_tag_q <= in_req_i.sphere_tag;
    end
  end

  // Stage 2: all component products, one multiplier each.
  logic signed [ProdW-1:0] s2_dd_q [3];  // d_i * d_i
  logic signed [ProdW-1:0] s2_ed_q [3];  // e_i * d_i
  logic signed [ProdW-1:0] s2_ca_q [3];  // first term of cross component i
  logic signed [ProdW-1:0] s2_cb_q [3];  // second term of cross component i
  logic [RsqW-1:0]         s2_rsq_q;
  logic [TagW-1:0]         s2_tag_q;

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      for (int i = 0; i < 3; i++) begin
        s2_dd_q[i] <= s1_d_q[i] * s1_d_q[i];
        s2_ed_q[i] <= s1_e_q[i] * s1_d_q[i];
      end
      s2_ca_q[0] <= s1_d_q[1] * s1_e_q[2];
      s2_cb_q[0] <= s1_d_q[2] * s1_e_q[1];
      s2_ca_q[1] <= s1_d_q[2] * s1_e_q[0];
      s2_cb_q[1] <= s1_d_q[0] * s1_e_q[2];
      s2_ca_q[2] <= s1_d_q[0] * s1_e_q[1];
      s2_cb_q[2] <= s1_d_q[1] * s1_e_q[0];
      s2_rsq_q   <= s1_rsq_q;
      s2_tag_q   <= s1_tag_q;
    end
  end

  // Stage 3: |d|^2, e.d and the cross product d x e.
  logic signed [ProdW:0]    s3_len_sum;
  logic signed [DotW-1:0]   s3_dot_d;
  logic signed [CrossW-1:0] s3_k_d [3];
  logic [LenW-1:0]          s3_len_q;
  logic signed [DotW-1:0]   s3_dot_q;
  logic signed [CrossW-1:0] s3_k_q [3];
  logic [RsqW-1:0]          s3_rsq_q;
  logic [TagW-1:0]          s3_tag_q;

  always_comb begin
    s3_len_sum = $signed({s2_dd_q[0][ProdW-1], s2_dd_q[0]})
               + $signed({s2_dd_q[1][ProdW-1], s2_dd_q[1]})
               + $signed({s2_dd_q[2][ProdW-1], s2_dd_q[2]});
    s3_dot_d   = $signed({s2_ed_q[0][ProdW-1], s2_ed_q[0]})
               + $signed({s2_ed_q[1][ProdW-1], s2_ed_q[1]})
               + $signed({s2_ed_q[2][ProdW-1], s2_ed_q[2]});
    for (int i = 0; i < 3; i++) begin
      s3_k_d[i] = $signed({s2_ca_q[i][ProdW-1], s2_ca_q[i]})
                - $signed({s2_cb_q[i][ProdW-1], s2_cb_q[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      // The sum of squares is never negative and fits the unsigned width.
      s3_len_q <= s3_len_sum[LenW-1:0];
      s3_dot_q <= s3_dot_d;
      s3_k_q   <= s3_k_d;
      s3_rsq_q <= s2_rsq_q;
      s3_tag_q <= s2_tag_q;
    end
  end

  // Stage 4: window test |d|^2 <= -2(e.d) <= 3|d|^2, zero-length flag, magnitudes.
  logic signed [WinW-1:0] s4_dot_ext;
  logic signed [WinW-1:0] s4_proj;
  logic signed [WinW-1:0] s4_len_ext;
  logic signed [WinW-1:0] s4_len3;
  logic signed [CrossW-1:0] s4_abs [3];
  logic                   s4_win_d;
  logic                   s4_win_q;
  logic                   s4_zero_q;
  logic [MagW-1:0]        s4_mag_q [3];
  logic [LenW-1:0]        s4_len_q;
  logic [RsqW-1:0]        s4_rsq_q;
  logic [TagW-1:0]        s4_tag_q;

  always_comb begin
    s4_dot_ext = $signed({{(WinW - DotW){s3_dot_q[DotW-1]}}, s3_dot_q});
    s4_proj    = -(s4_dot_ext <<< 1);
    s4_len_ext = $signed({{(WinW - LenW){1'b0}}, s3_len_q});
    s4_len3    = s4_len_ext + (s4_len_ext <<< 1);
    s4_win_d   = (s4_len_ext <= s4_proj) && (s4_proj <= s4_len3);
    for (int i = 0; i < 3; i++) begin
      s4_abs[i] = s3_k_q[i][CrossW-1] ? -s3_k_q[i] : s3_k_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      s4_win_q  <= s4_win_d;
      s4_zero_q <= (s3_len_q == '0);
      for (int i = 0; i < 3; i++) begin
        s4_mag_q[i] <= s4_abs[i][MagW-1:0];
      end
      s4_len_q  <= s3_len_q;
      s4_rsq_q  <= s3_rsq_q;
      s4_tag_q  <= s3_tag_q;
    end
  end

  // Stage 5: partial products of the three squares and of radius_sq * |d|^2.
  logic [SqPartW-1:0]  s5_hh_q [3];
  logic [SqPartW-1:0]  s5_hl_q [3];
  logic [SqPartW-1:0]  s5_ll_q [3];
  logic [BndPartW-1:0] s5_bhh_q;
  logic [BndPartW-1:0] s5_bhl_q;
  logic [BndPartW-1:0] s5_blh_q;
  logic [BndPartW-1:0] s5_bll_q;
  logic                s5_win_q;
  logic                s5_zero_q;
  logic [TagW-1:0]     s5_tag_q;

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      for (int i = 0; i < 3; i++) begin
        s5_hh_q[i] <= s4_mag_q[i][MagW-1:HalfW] * s4_mag_q[i][MagW-1:HalfW];
        s5_hl_q[i] <= s4_mag_q[i][MagW-1:HalfW] * s4_mag_q[i][HalfW-1:0];
        s5_ll_q[i] <= s4_mag_q[i][HalfW-1:0] * s4_mag_q[i][HalfW-1:0];
      end
      s5_bhh_q  <= s4_rsq_q[RsqW-1:RsqHalfW] * s4_len_q[LenW-1:HalfW];
      s5_bhl_q  <= s4_rsq_q[RsqW-1:RsqHalfW] * s4_len_q[HalfW-1:0];
      s5_blh_q  <= s4_rsq_q[RsqHalfW-1:0] * s4_len_q[LenW-1:HalfW];
      s5_bll_q  <= s4_rsq_q[RsqHalfW-1:0] * s4_len_q[HalfW-1:0];
      s5_win_q  <= s4_win_q;
      s5_zero_q <= s4_zero_q;
      s5_tag_q  <= s4_tag_q;
    end
  end

  // Stage 6: assemble each square and the bound from their partial products.
  logic [SqW-1:0]  s6_sq_d [3];
  logic [BndW-1:0] s6_bnd_d;
  logic [SqW-1:0]  s6_sq_q [3];
  logic [BndW-1:0] s6_bnd_q;
  logic            s6_win_q;
  logic            s6_zero_q;
  logic [TagW-1:0] s6_tag_q;

  always_comb begin
    // The middle term appears twice, hence one extra bit of shift.
    for (int i = 0; i < 3; i++) begin
      s6_sq_d[i] = (SqW'(s5_hh_q[i]) << (2 * HalfW))
                 + (SqW'(s5_hl_q[i]) << (HalfW + 1))
                 + SqW'(s5_ll_q[i]);
    end
    s6_bnd_d = (BndW'(s5_bhh_q) << (RsqHalfW + HalfW))
             + (BndW'(s5_bhl_q) << RsqHalfW)
             + (BndW'(s5_blh_q) << HalfW)
             + BndW'(s5_bll_q);
  end

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      s6_sq_q   <= s6_sq_d;
      s6_bnd_q  <= s6_bnd_d;
      s6_win_q  <= s5_win_q;
      s6_zero_q <= s5_zero_q;
      s6_tag_q  <= s5_tag_q;
    end
  end

  // Stage 7: squared norm of the cross product.
  logic [SqW-1:0]  s7_cross_q;
  logic [BndW-1:0] s7_bnd_q;
  logic            s7_win_q;
  logic            s7_zero_q;
  logic [TagW-1:0] s7_tag_q;

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      s7_cross_q <= s6_sq_q[0] + s6_sq_q[1] + s6_sq_q[2];
      s7_bnd_q   <= s6_bnd_q;
      s7_win_q   <= s6_win_q;
      s7_zero_q  <= s6_zero_q;
      s7_tag_q   <= s6_tag_q;
    end
  end

  // Stage 8: distance compare and the result register.
  ssht_res_t s8_res_d;
  ssht_res_t s8_res_q;

  always_comb begin
    s8_res_d.hit         = ~s7_zero_q & s7_win_q & (s7_cross_q <= SqW'(s7_bnd_q));
    s8_res_d.zero_length = s7_zero_q;
    s8_res_d.tag_out     = s7_tag_q;
  end

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      s8_res_q <= s8_res_d;
    end
  end

  assign out_res_o = s8_res_q;

endmodule

`default_nettype wire

>>> rtl/ssht_checker.sv
// Port-level checker for the segment sphere hit test, bound to the top level.
`default_nettype none

module ssht_checker
  import ssht_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire ssht_res_t out_res_o
);

  // Requests accepted whose results have not yet been taken.
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;
  logic            in_acc;
  logic            out_acc;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A stalled result stays put.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  // A zero-length segment never reports a hit.
  a_zero_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.zero_length |-> !out_res_o.hit)
    else $error("hit reported for a zero-length segment");

  // Back pressure reaches the input only when the output is stalled.
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && (cnt_q == CntW'(NumStages)))
    else $error("input stalled while the pipeline can move");

  // No result without a request in flight.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result with no request in flight");

  // Never more requests in flight than stages.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(NumStages))
    else $error("more requests in flight than stages");

endmodule

bind segment_sphere_hit_test ssht_checker u_ssht_checker (.*);

`default_nettype wire

>>> verif/ssht_score_pkg.sv
// Hit-test expectation tracker: predicts each result from its request and checks arrivals.
package ssht_score_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import ssht_pkg::*;

  class hit_scoreboard;
    ssht_res_t   expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned hits;
    int unsigned zeros;

    function new();
      errors  = 0;
      checked = 0;
      hits    = 0;
      zeros   = 0;
    endfunction

    // Exact segment versus sphere outcome for one request.
    function ssht_res_t segment_outcome(ssht_req_t r);
      longint      dx, dy, dz, ex, ey, ez;
      longint      len2, dot, proj, kx, ky, kz;
      logic [127:0] mx, my, mz, cross2, bound;
      ssht_res_t   res;
      dx   = longint'($signed(r.new_x)) - longint'($signed(r.old_x));
      dy   = longint'($signed(r.new_y)) - longint'($signed(r.old_y));
      dz   = longint'($signed(r.new_z)) - longint'($signed(r.old_z));
      ex   = longint'($signed(r.old_x)) - longint'($signed(r.centre_x));
      ey   = longint'($signed(r.old_y)) - longint'($signed(r.centre_y));
      ez   = longint'($signed(r.old_z)) - longint'($signed(r.centre_z));
      len2 = dx * dx + dy * dy + dz * dz;
      dot  = ex * dx + ey * dy + ez * dz;
      res.zero_length = (len2 == 0);
      res.tag_out     = r.sphere_tag;
      res.hit         = 1'b0;
      if (len2 != 0) begin
        // Window test with the division by |d|^2 cross-multiplied away.
        proj   = -2 * dot;
        kx     = dy * ez - dz * ey;
        ky     = dz * ex - dx * ez;
        kz     = dx * ey - dy * ex;
        mx     = (kx < 0) ? 128'(-kx) : 128'(kx);
        my     = (ky < 0) ? 128'(-ky) : 128'(ky);
        mz     = (kz < 0) ? 128'(-kz) : 128'(kz);
        cross2 = mx * mx + my * my + mz * mz;
        bound  = 128'(r.radius_sq) * 128'(len2);
        res.hit = (len2 <= proj) && (proj <= 3 * len2) && (cross2 <= bound);
      end
      return res;
    endfunction

    // Mismatches print one line each and are counted.
    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void note_request(ssht_req_t r);
      expected_q.push_back(segment_outcome(r));
    endfunction

    task check_result(ssht_res_t got);
      ssht_res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with tag %0d arrived with no request pending", got.tag_out));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.hit) hits++;
      if (want.zero_length) zeros++;
      if (got.hit !== want.hit) begin
        report($sformatf("result %0d: hit %b, expected %b", checked, got.hit, want.hit));
      end
      if (got.zero_length !== want.zero_length) begin
        report($sformatf("result %0d: zero_length %b, expected %b", checked,
                         got.zero_length, want.zero_length));
      end
      if (got.tag_out !== want.tag_out) begin
        report($sformatf("result %0d: tag_out %0d, expected %0d", checked,
                         got.tag_out, want.tag_out));
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

>>> verif/tb_top.sv
// Stimulus, handshake drivers and end-of-run checks for the segment sphere hit test.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssht_pkg::*;
  import ssht_score_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam longint      CoordMax    = 64'sd8388607;
  localparam longint      CoordMin    = -64'sd8388608;
  localparam logic [47:0] RsqMax      = '1;
  localparam int unsigned RandomCount = 1000;
  localparam int unsigned QuietFrom   = 850;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  ssht_req_t in_req_i    = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  ssht_res_t out_res_o;

  hit_scoreboard sb;
  int unsigned   cycle_count       = 0;
  int unsigned   hold_off_request  = 0;
  int unsigned   hold_left         = 0;
  int unsigned   stall_left        = 0;
  bit            no_idle           = 1'b0;
  int unsigned   sent              = 0;

  segment_sphere_hit_test u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: check accepted results, then choose the next ready value.
  initial begin
    sb = new();
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) sb.check_result(out_res_o);
      if (hold_left == 0 && hold_off_request != 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Random signed value whose magnitude has up to maxbits bits.
  function automatic longint rand_span(int unsigned maxbits);
    int unsigned b;
    longint      m;
    b = $urandom_range(0, maxbits);
    m = longint'({$urandom, $urandom}) & ((64'sd1 <<< b) - 1);
    return ($urandom_range(0, 1) != 0) ? -m : m;
  endfunction

  function automatic ssht_req_t mk(longint ox, longint oy, longint oz,
                                   longint nx, longint ny, longint nz,
                                   longint cx, longint cy, longint cz,
                                   logic [47:0] rsq, logic [7:0] tag);
    ssht_req_t r;
    r.old_x      = 24'(ox);
    r.old_y      = 24'(oy);
    r.old_z      = 24'(oz);
    r.new_x      = 24'(nx);
    r.new_y      = 24'(ny);
    r.new_z      = 24'(nz);
    r.centre_x   = 24'(cx);
    r.centre_y   = 24'(cy);
    r.centre_z   = 24'(cz);
    r.radius_sq  = rsq;
    r.sphere_tag = tag;
    return r;
  endfunction

  // Every bit of every field drawn at random.
  function automatic ssht_req_t any_request();
    return ssht_req_t'(272'({$urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom}));
  endfunction

  // A step with the centre placed near the segment, so hits and near misses both occur.
  function automatic ssht_req_t aimed_request();
    longint      o[3];
    longint      d[3];
    longint      off[3];
    longint      c[3];
    longint      k;
    bit          still;
    logic [47:0] off2;
    logic [47:0] rsq;
    still = ($urandom_range(0, 24) == 0);
    k     = longint'($urandom_range(0, 8));
    for (int i = 0; i < 3; i++) begin
      o[i]   = rand_span(22);
      d[i]   = still ? 0 : rand_span(21);
      off[i] = rand_span(20);
      c[i]   = o[i] + (k * d[i]) / 4 + off[i];
    end
    off2 = 48'(off[0] * off[0] + off[1] * off[1] + off[2] * off[2]);
    case ($urandom_range(0, 3))
      0:       rsq = off2;
      1:       rsq = off2 >> $urandom_range(1, 8);
      2:       rsq = 48'({$urandom, $urandom});
      default: rsq = off2 + 48'($urandom_range(0, 1000));
    endcase
    return mk(o[0], o[1], o[2], o[0] + d[0], o[1] + d[1], o[2] + d[2],
              c[0], c[1], c[2], rsq, 8'($urandom));
  endfunction

  // Offer one request, optionally after an idle burst, and wait for its acceptance.
  task automatic send_request(ssht_req_t req, bit may_idle);
    if (may_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_request(req);
    sent++;
  endtask

  // Stop offering and wait until every pending result has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    ssht_req_t directed_q[$];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes, zero-length steps, and exact window and radius boundaries.
    directed_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, '0, 8'd0));
    directed_q.push_back(mk(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax,
                            CoordMin, CoordMin, CoordMin, RsqMax, 8'd1));
    directed_q.push_back(mk(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin,
                            0, 0, 0, RsqMax, 8'd255));
    directed_q.push_back(mk(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax,
                            CoordMax, CoordMax, CoordMax, '0, 8'd3));
    directed_q.push_back(mk(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax,
                            CoordMax, CoordMax, CoordMax, RsqMax, 8'd4));
    directed_q.push_back(mk(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax,
                            0, 0, 0, '0, 8'd5));
    directed_q.push_back(mk(CoordMax, CoordMin, CoordMax, CoordMin, CoordMax, CoordMin,
                            CoordMin, CoordMax, CoordMin, RsqMax, 8'd6));
    // Lower window end, radius bound met and just missed.
    directed_q.push_back(mk(0, 0, 0, 2, 0, 0, 1, 5, 0, 48'd25, 8'd7));
    directed_q.push_back(mk(0, 0, 0, 2, 0, 0, 1, 5, 0, 48'd24, 8'd8));
    // Upper window end, radius bound met and just missed.
    directed_q.push_back(mk(0, 0, 0, 2, 0, 0, 3, 5, 0, 48'd25, 8'd9));
    directed_q.push_back(mk(0, 0, 0, 2, 0, 0, 3, 5, 0, 48'd24, 8'd10));
    // Just outside either window end with a huge radius.
    directed_q.push_back(mk(0, 0, 0, 100, 0, 0, 49, 0, 0, RsqMax, 8'd11));
    directed_q.push_back(mk(0, 0, 0, 100, 0, 0, 151, 0, 0, RsqMax, 8'd12));
    // Centre on the line itself with a zero radius.
    directed_q.push_back(mk(0, 0, 0, 2, 0, 0, 2, 0, 0, '0, 8'd13));
    // Step along negative z, upper window end, both sides of the radius bound.
    directed_q.push_back(mk(0, 0, 0, 0, 0, -2, 0, 3, -3, 48'd9, 8'd14));
    directed_q.push_back(mk(0, 0, 0, 0, 0, -2, 0, 3, -3, 48'd8, 8'd15));
    // Centre behind the starting point.
    directed_q.push_back(mk(0, 0, 0, 4, 0, 0, -4, 0, 0, RsqMax, 8'd16));
    foreach (directed_q[i]) send_request(directed_q[i], 1'b1);

    // The sender pauses until the pipeline has emptied.
    drain();

    // Long result stall while requests keep coming, so the pipeline fills and backs up.
    hold_off_request = 60;
    for (int i = 0; i < 30; i++) send_request(aimed_request(), 1'b0);

    // Random mix with idling on both sides; the final stretch runs without idling.
    for (int i = 0; i < RandomCount; i++) begin
      no_idle = (i >= QuietFrom);
      send_request(($urandom_range(0, 9) < 7) ? aimed_request() : any_request(), !no_idle);
    end

    drain();
    repeat (NumStages + 4) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Sent %0d requests and checked %0d results in %0d cycles.",
             sent, sb.checked, cycle_count);
    $display("Results covered %0d hits, %0d zero-length steps and %0d misses.",
             sb.hits, sb.zeros, sb.checked - sb.hits - sb.zeros);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> segment_sphere_hit_test.f
rtl/ssht_pkg.sv
rtl/segment_sphere_hit_test.sv
rtl/ssht_checker.sv
verif/ssht_score_pkg.sv
verif/tb_top.sv
